/* design/picr_pkg.sv */
// Shared types and constants for the pulse interval capture ring.
`timescale 1ns / 1ps

package picr_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned RD_INDEX_W = 4;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned WR_INDEX_W = 4;
  localparam int unsigned USED_W     = 5;

  localparam logic [INTERVAL_W-1:0] OVERFLOW_PERIOD_RESET = 16'hFFFF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_PULSE = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

endpackage

/* design/picr_in_if.sv */
// Request channel carrying one opcode and read index per transfer.
`timescale 1ns / 1ps

interface picr_in_if;
  import picr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [RD_INDEX_W-1:0] read_index;

  modport source (output valid, output opcode, output read_index, input ready);
  modport sink (input valid, input opcode, input read_index, output ready);
endinterface

/* design/picr_out_if.sv */
// Result channel carrying the capture status and read data of one request.
`timescale 1ns / 1ps

interface picr_out_if;
  import picr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  event_captured;
  logic [INTERVAL_W-1:0] captured_interval;
  logic [WR_INDEX_W-1:0] write_index;
  logic [USED_W-1:0]     used_count;
  logic                  buffer_full;
  logic                  below_min_speed;
  logic                  overflow_seen;
  logic [INTERVAL_W-1:0] read_data;

  modport source (
    output valid, output event_captured, output captured_interval, output write_index,
    output used_count, output buffer_full, output below_min_speed, output overflow_seen,
    output read_data, input ready
  );
  modport sink (
    input valid, input event_captured, input captured_interval, input write_index,
    input used_count, input buffer_full, input below_min_speed, input overflow_seen,
    input read_data, output ready
  );
endinterface

/* design/picr_store.sv */
// Interval ring memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps

module picr_store #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [$clog2(RING_DEPTH)-1:0]         wr_addr,
  input  logic [picr_pkg::INTERVAL_W-1:0]       wr_data,
  input  logic                                  rd_load,
  input  logic                                  rd_en,
  input  logic [$clog2(RING_DEPTH)-1:0]         rd_addr,
  output logic [picr_pkg::INTERVAL_W-1:0]       rd_data
);
  import picr_pkg::*;

  logic [INTERVAL_W-1:0] mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld;
  logic [INTERVAL_W-1:0] rd_raw;
  logic                  rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_load) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_load) begin
        rd_hit <= rd_en && vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

/* design/pulse_interval_capture_ring.sv */
// Pulse interval capture ring: measures time between sensor pulses in timer ticks.
// Requests arrive on sensor_in: opcode 0 is a timer tick, 1 a sensor pulse and
// 2 a read of one stored interval at read_index. Every request yields exactly
// one result on result_out with the capture fields, the ring status and the
// read data. A tick that reaches overflow_period marks the speed as too slow,
// rewinds the ring and makes the next pulse store zero at entry 0.
// The configuration port writes overflow_period when cfg_we is high; write it
// only while no request is outstanding.
// The result is valid in the cycle after acceptance, and one request is taken
// every cycle while the receiver keeps up: all state updates and the ring write
// happen in the acceptance cycle, and the result register holds the outcome.
// When the receiver stalls, the result register holds and sensor_in.ready
// drops until the result is taken; a result taken in the same cycle lets a new
// request in at once. Synchronous reset clears the counter, pointer, flags and
// entry valid bits, so every entry reads as zero until written, and sets
// overflow_period to 65535.
`timescale 1ns / 1ps

module pulse_interval_capture_ring #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [picr_pkg::INTERVAL_W-1:0] cfg_wdata,
  picr_in_if.sink                         sensor_in,
  picr_out_if.source                      result_out
);
  import picr_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

  logic [INTERVAL_W-1:0] overflow_period;
  logic [INTERVAL_W-1:0] tick_counter, tick_counter_next;
  logic [IDX_W-1:0]      ring_pointer, ring_pointer_next;
  logic [CNT_W-1:0]      valid_entries, valid_entries_next;
  logic                  ring_wrapped, ring_wrapped_next;
  logic                  skip_first, skip_first_next;
  logic                  slow_flag, slow_flag_next;

  logic                  accept;
  logic                  out_valid;
  logic [INTERVAL_W-1:0] tick_inc;
  logic [CNT_W-1:0]      pulse_ptr;
  logic [INTERVAL_W-1:0] cap_value;
  logic                  cap_en;
  logic                  ovf;
  logic                  rd_en;
  logic                  rd_in_range;
  logic [INTERVAL_W-1:0] rd_data;

  logic                  event_captured;
  logic [INTERVAL_W-1:0] captured_interval;
  logic [WR_INDEX_W-1:0] write_index;
  logic                  overflow_seen;

  assign accept          = sensor_in.valid && sensor_in.ready;
  assign sensor_in.ready = !out_valid || result_out.ready;
  assign tick_inc        = tick_counter + 1'b1;
  assign rd_in_range     = 32'(sensor_in.read_index) < RING_DEPTH;

  always_comb begin
    tick_counter_next  = tick_counter;
    ring_pointer_next  = ring_pointer;
    valid_entries_next = valid_entries;
    ring_wrapped_next  = ring_wrapped;
    skip_first_next    = skip_first;
    slow_flag_next     = slow_flag;
    pulse_ptr          = CNT_W'(ring_pointer);
    cap_value          = '0;
    cap_en             = 1'b0;
    ovf                = 1'b0;
    rd_en              = 1'b0;
    case (sensor_in.opcode)
      OP_TICK: begin
        if (tick_inc >= overflow_period) begin
          ovf               = 1'b1;
          ring_pointer_next = '0;
          ring_wrapped_next = 1'b0;
          skip_first_next   = 1'b1;
          slow_flag_next    = 1'b1;
          tick_counter_next = '0;
        end else begin
          tick_counter_next = tick_inc;
        end
      end
      OP_PULSE: begin
        cap_en = 1'b1;
        if (skip_first) begin
          ring_wrapped_next = 1'b0;
          skip_first_next   = 1'b0;
          cap_value         = '0;
        end else begin
          slow_flag_next = 1'b0;
          pulse_ptr      = CNT_W'(ring_pointer) + 1'b1;
          cap_value      = tick_counter;
        end
        if (!ring_wrapped_next) begin
          valid_entries_next = pulse_ptr + 1'b1;
        end
        if (pulse_ptr >= DEPTH_CNT) begin
          pulse_ptr          = '0;
          valid_entries_next = DEPTH_CNT;
          ring_wrapped_next  = 1'b1;
        end
        ring_pointer_next = IDX_W'(pulse_ptr);
        tick_counter_next = '0;
      end
      OP_READ: begin
        rd_en = rd_in_range;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_period <= OVERFLOW_PERIOD_RESET;
      tick_counter    <= '0;
      ring_pointer    <= '0;
      valid_entries   <= '0;
      ring_wrapped    <= 1'b0;
      skip_first      <= 1'b0;
      slow_flag       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        overflow_period <= cfg_wdata;
      end
      if (accept) begin
        tick_counter  <= tick_counter_next;
        ring_pointer  <= ring_pointer_next;
        valid_entries <= valid_entries_next;
        ring_wrapped  <= ring_wrapped_next;
        skip_first    <= skip_first_next;
        slow_flag     <= slow_flag_next;
        out_valid     <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture fields are registered; status fields come from the state registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      event_captured    <= cap_en;
      captured_interval <= cap_value;
      write_index       <= cap_en ? WR_INDEX_W'(pulse_ptr) : '0;
      overflow_seen     <= ovf;
    end
  end

  picr_store #(
    .RING_DEPTH(RING_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && cap_en),
    .wr_addr (IDX_W'(pulse_ptr)),
    .wr_data (cap_value),
    .rd_load (accept),
    .rd_en   (rd_en),
    .rd_addr (IDX_W'(sensor_in.read_index)),
    .rd_data (rd_data)
  );

  assign result_out.valid             = out_valid;
  assign result_out.event_captured    = event_captured;
  assign result_out.captured_interval = captured_interval;
  assign result_out.write_index       = write_index;
  assign result_out.used_count        = USED_W'(valid_entries);
  assign result_out.buffer_full       = ring_wrapped;
  assign result_out.below_min_speed   = slow_flag;
  assign result_out.overflow_seen     = overflow_seen;
  assign result_out.read_data         = rd_data;

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(valid_entries) <= RING_DEPTH)
    else $error("used entry count exceeds ring depth");

  a_wrapped_full: assert property (@(posedge clk) disable iff (rst)
    ring_wrapped |-> valid_entries == DEPTH_CNT)
    else $error("wrapped ring without full used count");

  a_overflow_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow_seen |-> slow_flag && !ring_wrapped && skip_first)
    else $error("overflow result with inconsistent status");

  a_capture_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_captured |-> !overflow_seen && !skip_first)
    else $error("capture reported together with overflow or pending first pulse");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the pulse interval capture ring, with directed and random requests.
`timescale 1ns / 1ps

module tb_top;
  import picr_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SEGMENT_REQUESTS = 225;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic                  captured;
    logic [INTERVAL_W-1:0] interval;
    logic [WR_INDEX_W-1:0] wr_index;
    logic [USED_W-1:0]     used;
    logic                  full;
    logic                  slow;
    logic                  overflow;
    logic [INTERVAL_W-1:0] rd_data;
  } capture_status_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [INTERVAL_W-1:0] cfg_wdata;

  picr_in_if  sensor_if ();
  picr_out_if result_if ();

  pulse_interval_capture_ring #(
    .RING_DEPTH(DEPTH)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sensor_in (sensor_if),
    .result_out(result_if)
  );

  // Shadow state of the capture logic.
  logic [INTERVAL_W-1:0] overflow_limit = OVERFLOW_PERIOD_RESET;
  logic [INTERVAL_W-1:0] tick_count = '0;
  int unsigned           ring_ptr = 0;
  logic [USED_W-1:0]     used_entries = '0;
  logic                  ring_full = 1'b0;
  logic                  first_pending = 1'b0;
  logic                  too_slow = 1'b0;
  logic [INTERVAL_W-1:0] intervals [DEPTH];

  capture_status_t pending_status [$];
  int unsigned     mismatches = 0;
  int unsigned     cycles = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic capture_status_t next_capture_status(input logic [OPCODE_W-1:0] op,
                                                          input logic [RD_INDEX_W-1:0] idx);
    capture_status_t st;
    logic [INTERVAL_W-1:0] bumped;
    st = '{default: '0};
    case (op)
      OP_TICK: begin
        bumped = tick_count + 1'b1;
        if (bumped >= overflow_limit) begin
          st.overflow = 1'b1;
          ring_ptr = 0;
          ring_full = 1'b0;
          first_pending = 1'b1;
          too_slow = 1'b1;
          tick_count = '0;
        end else begin
          tick_count = bumped;
        end
      end
      OP_PULSE: begin
        if (first_pending) begin
          ring_full = 1'b0;
          first_pending = 1'b0;
          tick_count = '0;
        end else begin
          too_slow = 1'b0;
          ring_ptr++;
        end
        if (!ring_full) used_entries = USED_W'(ring_ptr + 1);
        if (ring_ptr >= DEPTH) begin
          ring_ptr = 0;
          used_entries = USED_W'(DEPTH);
          ring_full = 1'b1;
        end
        intervals[ring_ptr] = tick_count;
        st.captured = 1'b1;
        st.interval = tick_count;
        st.wr_index = WR_INDEX_W'(ring_ptr);
        tick_count = '0;
      end
      OP_READ: begin
        st.rd_data = intervals[idx];
      end
      default: begin
      end
    endcase
    st.used = used_entries;
    st.full = ring_full;
    st.slow = too_slow;
    return st;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    capture_status_t want;
    if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (pending_status.size() == 0) begin
        $display("%0t ns: result with no request outstanding", $time);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        compare_field("event_captured", 16'(want.captured), 16'(result_if.event_captured));
        compare_field("captured_interval", want.interval, result_if.captured_interval);
        compare_field("write_index", 16'(want.wr_index), 16'(result_if.write_index));
        compare_field("used_count", 16'(want.used), 16'(result_if.used_count));
        compare_field("buffer_full", 16'(want.full), 16'(result_if.buffer_full));
        compare_field("below_min_speed", 16'(want.slow), 16'(result_if.below_min_speed));
        compare_field("overflow_seen", 16'(want.overflow), 16'(result_if.overflow_seen));
        compare_field("read_data", want.rd_data, result_if.read_data);
      end
    end
  end

  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [RD_INDEX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sensor_if.valid = 1'b0;
      @(negedge clk);
    end
    sensor_if.opcode = op;
    sensor_if.read_index = idx;
    sensor_if.valid = 1'b1;
    @(posedge clk);
    while (sensor_if.ready !== 1'b1) @(posedge clk);
    pending_status.push_back(next_capture_status(op, idx));
  endtask

  task automatic settle();
    @(negedge clk);
    sensor_if.valid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_period(input logic [INTERVAL_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    overflow_limit = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Pulses right after reset start at entry 1, since no first pulse is pending.
  task automatic test_first_pulses();
    send_request(OP_PULSE, 4'd0);
    send_request(OP_TICK, 4'd0);
    send_request(OP_TICK, 4'd0);
    send_request(OP_PULSE, 4'd0);
    send_request(OP_READ, 4'd0);
    send_request(OP_READ, 4'd1);
    send_request(OP_READ, 4'd2);
    send_request(OP_READ, 4'd15);
    send_request(OP_UNUSED, 4'd9);
  endtask

  // After an overflow the first pulse stores zero at entry 0 and the second clears the slow flag.
  task automatic test_overflow_restart();
    write_period(16'd3);
    repeat (3) send_request(OP_TICK, 4'd0);
    send_request(OP_PULSE, 4'd0);
    send_request(OP_TICK, 4'd0);
    send_request(OP_PULSE, 4'd0);
    send_request(OP_READ, 4'd0);
  endtask

  task automatic test_period_lowered();
    write_period(16'd1000);
    repeat (4) send_request(OP_TICK, 4'd0);
    write_period(16'd2);
    send_request(OP_TICK, 4'd0);
  endtask

  task automatic test_period_zero();
    write_period(16'd0);
    send_request(OP_TICK, 4'd0);
    send_request(OP_PULSE, 4'd0);
    send_request(OP_TICK, 4'd0);
  endtask

  task automatic test_random_stream(input int unsigned count);
    int unsigned pick;
    logic [OPCODE_W-1:0] op;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 52) op = OP_TICK;
      else if (pick < 80) op = OP_PULSE;
      else if (pick < 95) op = OP_READ;
      else op = OP_UNUSED;
      send_request(op, RD_INDEX_W'($urandom_range(DEPTH - 1)));
    end
  endtask

  task automatic test_random_phase(input int unsigned phase, input int unsigned s_pct,
                                   input int unsigned r_pct);
    int unsigned seg;
    settle();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned s = 0; s < 3; s++) begin
      seg = phase * 3 + s;
      case (seg)
        0: write_period(16'hFFFF);
        4: write_period(16'd1);
        8: write_period(INTERVAL_W'($urandom_range(200, 65534)));
        default: write_period(INTERVAL_W'($urandom_range(2, 24)));
      endcase
      test_random_stream(SEGMENT_REQUESTS);
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) intervals[i] = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sensor_if.valid = 1'b0;
    sensor_if.opcode = OP_TICK;
    sensor_if.read_index = '0;
    result_if.ready = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 75;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_first_pulses();
    test_overflow_restart();
    test_period_lowered();
    test_period_zero();
    test_random_phase(0, 19, 75);
    test_random_phase(1, 75, 19);
    test_random_phase(2, 0, 0);

    settle();
    repeat (3) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
